// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers. Both forms sample on the rising clock edge and are
// switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/lrb_pkg.sv -----
package lrb_pkg;

  localparam int DATA_W   = 8;
  localparam int LEN_W    = 7;
  localparam int COUNT_W  = 6;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam logic [DATA_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [DATA_W-1:0] CHAR_NUL = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_LINE  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NO_LINE = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_in;
    logic    do_write;
    logic    do_clear;
    logic    set_status;
    status_t status;
    logic    start_read;
    logic    start_scan;
    logic    scan_step;
    logic    start_line_emit;
    logic    rd_step;
    logic    load_byte;
    logic    load_status;
  } lrb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic read_none;
    logic used_zero;
    logic term_hit;
    logic scan_end;
    logic remain_zero;
    logic out_free;
  } lrb_sts_t;

endpackage

// ----- hw/rtl/lrb_req_if.sv -----
interface lrb_req_if import lrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] data_byte;
  logic [LEN_W-1:0]  block_length;
  logic              block_first;
  logic [LEN_W-1:0]  read_count;

  modport source (
    output valid, operation, data_byte, block_length, block_first, read_count,
    input  ready
  );

  modport sink (
    input  valid, operation, data_byte, block_length, block_first, read_count,
    output ready
  );
endinterface

// ----- hw/rtl/lrb_rsp_if.sv -----
interface lrb_rsp_if import lrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   out_byte;
  logic                last;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  used_count;
  logic [COUNT_W-1:0]  free_count;

  modport source (
    output valid, out_byte, last, status, used_count, free_count,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last, status, used_count, free_count,
    output ready
  );
endinterface

// ----- hw/rtl/lrb_ram.sv -----
module lrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/lrb_ctrl.sv -----
module lrb_ctrl import lrb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  lrb_sts_t sts,
  output lrb_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RD,
    S_EMIT,
    S_PUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = ST_OK;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_WRITE: begin
            cmd.do_write = 1'b1;
            state_next   = S_PUT;
          end
          OP_CLEAR: begin
            cmd.do_clear = 1'b1;
            state_next   = S_PUT;
          end
          OP_READ: begin
            if (sts.read_none) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
              state_next     = S_PUT;
            end else begin
              cmd.start_read = 1'b1;
              state_next     = S_RD;
            end
          end
          OP_LINE: begin
            if (sts.used_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NO_LINE;
              state_next     = S_PUT;
            end else begin
              cmd.start_scan = 1'b1;
              state_next     = S_SCAN_RD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN_RD: begin
        cmd.scan_step = 1'b1;
        state_next    = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.term_hit) begin
          cmd.start_line_emit = 1'b1;
          state_next          = S_RD;
        end else if (sts.scan_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NO_LINE;
          state_next     = S_PUT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_RD: begin
        cmd.rd_step = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_byte = 1'b1;
          state_next    = sts.remain_zero ? S_IDLE : S_RD;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.load_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/lrb_dp.sv -----
`include "assert_macros.svh"

module lrb_dp import lrb_pkg::*; #(
  parameter int STORE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [OP_W-1:0]   operation,
  input  logic [DATA_W-1:0] data_byte,
  input  logic [LEN_W-1:0]  block_length,
  input  logic              block_first,
  input  logic [LEN_W-1:0]  read_count,
  input  lrb_cmd_t          cmd,
  output lrb_sts_t          sts,
  lrb_rsp_if.source         rsp
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(STORE_DEPTH - 1);

  // Latched input item.
  op_t               op_q;
  logic [DATA_W-1:0] data_q;
  logic [LEN_W-1:0]  blen_q;
  logic              first_q;
  logic [LEN_W-1:0]  rcount_q;

  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic          block_accepted;
  logic [AW-1:0] addr;
  logic [AW-1:0] remain;
  logic [AW-1:0] scan_cnt;
  logic          line_mode;
  status_t       put_status;

  logic                out_valid;
  logic [DATA_W-1:0]   out_byte;
  logic                out_last;
  status_t             out_status;
  logic [COUNT_W-1:0]  out_used_cnt;
  logic [COUNT_W-1:0]  out_free_cnt;

  logic [AW:0]       diff;
  logic [AW-1:0]     used;
  logic [AW-1:0]     free;
  logic [AW-1:0]     read_n;
  logic [AW:0]       rp_sum;
  logic [AW-1:0]     rp_after_read;
  logic              acc_eff;
  logic              wr_ok;
  logic              mem_we;
  logic              mem_re;
  logic [DATA_W-1:0] mem_rd;
  logic              out_free;
  logic              load;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    diff = {1'b0, wp} - {1'b0, rp};
    if (diff[AW]) begin
      used = AW'(diff + (AW+1)'(STORE_DEPTH));
    end else begin
      used = AW'(diff);
    end
    free = LAST_SLOT - used;

    read_n = (rcount_q > LEN_W'(used)) ? used : AW'(rcount_q);
    rp_sum = {1'b0, rp} + {1'b0, read_n};
    if (rp_sum >= (AW+1)'(STORE_DEPTH)) begin
      rp_after_read = AW'(rp_sum - (AW+1)'(STORE_DEPTH));
    end else begin
      rp_after_read = AW'(rp_sum);
    end

    // A block's first byte decides for the whole block; later bytes follow.
    acc_eff = first_q ? ((blen_q != '0) && (blen_q <= LEN_W'(free))) : block_accepted;
    wr_ok   = acc_eff && (free != '0);
  end

  assign mem_we   = cmd.do_write && wr_ok;
  assign mem_re   = cmd.scan_step || cmd.rd_step;
  assign out_free = !out_valid || rsp.ready;
  assign load     = cmd.load_byte || cmd.load_status;

  lrb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wp),
    .wdata(data_q),
    .re   (mem_re),
    .raddr(addr),
    .rdata(mem_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q     <= op_t'(operation);
      data_q   <= data_byte;
      blen_q   <= block_length;
      first_q  <= block_first;
      rcount_q <= read_count;
    end
    if (cmd.set_status) begin
      put_status <= cmd.status;
    end
    if (cmd.do_write) begin
      put_status <= wr_ok ? ST_OK : ST_REJECT;
    end
    if (cmd.do_clear) begin
      put_status <= ST_OK;
    end
    if (cmd.start_read) begin
      addr      <= rp;
      remain    <= read_n;
      line_mode <= 1'b0;
    end
    if (cmd.start_scan) begin
      addr      <= rp;
      scan_cnt  <= '0;
      line_mode <= 1'b1;
    end
    if (cmd.scan_step) begin
      addr     <= next_slot(addr);
      scan_cnt <= scan_cnt + AW'(1);
    end
    // The scan address has just passed the terminator: it becomes the new
    // read pointer, and emission restarts from the old one.
    if (cmd.start_line_emit) begin
      addr   <= rp;
      remain <= scan_cnt;
    end
    if (cmd.rd_step) begin
      addr   <= next_slot(addr);
      remain <= remain - AW'(1);
    end
    if (cmd.load_byte) begin
      out_byte   <= (line_mode && remain == '0) ? CHAR_NUL : mem_rd;
      out_last   <= (remain == '0);
      out_status <= ST_OK;
    end
    if (cmd.load_status) begin
      out_byte   <= '0;
      out_last   <= 1'b1;
      out_status <= put_status;
    end
    // Every pointer move of a step lands before its first result is loaded,
    // and the counts are held with the result while it waits.
    if (load) begin
      out_used_cnt <= COUNT_W'(used);
      out_free_cnt <= COUNT_W'(free);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp             <= '0;
      rp             <= '0;
      block_accepted <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.do_write) begin
        block_accepted <= wr_ok;
        if (wr_ok) begin
          wp <= next_slot(wp);
        end
      end
      if (cmd.do_clear) begin
        wp             <= '0;
        rp             <= '0;
        block_accepted <= 1'b0;
      end
      if (cmd.start_read) begin
        rp <= rp_after_read;
      end
      if (cmd.start_line_emit) begin
        rp <= addr;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.op          = op_q;
    sts.read_none   = (read_n == '0);
    sts.used_zero   = (used == '0);
    sts.term_hit    = (mem_rd == CHAR_CR) || (mem_rd == CHAR_LF) || (mem_rd == CHAR_NUL);
    sts.scan_end    = (scan_cnt == used);
    sts.remain_zero = (remain == '0);
    sts.out_free    = out_free;
  end

  assign rsp.valid      = out_valid;
  assign rsp.out_byte   = out_byte;
  assign rsp.last       = out_last;
  assign rsp.status     = out_status;
  assign rsp.used_count = out_used_cnt;
  assign rsp.free_count = out_free_cnt;

  `ASSERT_IMPL(a_no_overrun, clk, rst, mem_we, used != LAST_SLOT, "write into a full store")
  `ASSERT_IMPL(a_out_hold, clk, rst, load && out_valid, rsp.ready, "result overwritten before taken")
  `ASSERT_ALWAYS(a_ptr_range, clk, rst, (wp <= LAST_SLOT) && (rp <= LAST_SLOT), "pointer out of range")
  `ASSERT_IMPL(a_line_end_zero, clk, rst, $past(cmd.load_byte && line_mode && remain == '0), out_byte == CHAR_NUL && out_last, "line terminator not replaced by zero")

endmodule

// ----- hw/rtl/line_ring_buffer.sv -----
// Byte ring buffer of STORE_DEPTH slots (2 to 64) that holds at most
// STORE_DEPTH-1 bytes. Write blocks are all or nothing, decided on the first
// byte of the block; reads return up to the requested count; line reads return
// bytes up to the first CR, LF or NUL with the terminator given as zero, and
// consume nothing when no terminator is stored. Every item yields one or more
// results, each carrying the used and free counts after the item. One item is
// worked on at a time, and the store has a single registered read port: a
// write, clear or failed read is executed and its status result then loaded;
// a read reads and returns its bytes one at a time; a line read first scans
// the stored bytes one at a time up to the terminator, then rereads and
// returns them, or gives a status result when no terminator is found.
// A new item may be accepted while the last result still waits in the output
// register. The store needs no initialisation after reset.
module line_ring_buffer import lrb_pkg::*; #(
  parameter int STORE_DEPTH = 64
) (
  input logic       clk,
  input logic       rst,
  lrb_req_if.sink   req,
  lrb_rsp_if.source rsp
);

  lrb_cmd_t cmd;
  lrb_sts_t sts;

  lrb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lrb_dp #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .operation   (req.operation),
    .data_byte   (req.data_byte),
    .block_length(req.block_length),
    .block_first (req.block_first),
    .read_count  (req.read_count),
    .cmd         (cmd),
    .sts         (sts),
    .rsp         (rsp)
  );

endmodule

// ----- sim/line_ring_buffer_tb.sv -----
module line_ring_buffer_tb import lrb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  typedef struct packed {
    op_t              op;
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  block_length;
    logic              block_first;
    logic [LEN_W-1:0]  read_count;
    logic              drain;
  } req_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  out_byte;
    logic               last;
    status_t            status;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] free_count;
  } result_t;

  logic clk;
  logic rst;

  lrb_req_if req();
  lrb_rsp_if rsp();

  line_ring_buffer DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  req_item_t pending_items[$];
  result_t   expected_bytes[$];

  int   total_items = 0;
  int   sent_items  = 0;
  int   done_items  = 0;
  int   fail_count  = 0;
  int   src_gap     = 0;
  int   snk_gap     = 0;
  logic hold_off    = 1'b0;

  // Mirror of the buffer contents and pointers.
  logic [DATA_W-1:0] ring [DEPTH];
  int unsigned       wr_idx     = 0;
  int unsigned       rd_idx     = 0;
  bit                block_open = 1'b0;

  logic src_idle_on;
  logic snk_idle_on;

  // Idling pauses every third stretch of items and stops in the last part of the run.
  assign src_idle_on = ((sent_items / 50) % 3 != 1) && (sent_items + 40 < total_items);
  assign snk_idle_on = ((done_items / 40) % 3 != 2) && (done_items + 40 < total_items);

  function automatic int unsigned ring_used();
    return (wr_idx + DEPTH - rd_idx) % DEPTH;
  endfunction

  function automatic int unsigned ring_free();
    return DEPTH - 1 - ring_used();
  endfunction

  function automatic void add_expected(logic [DATA_W-1:0] b, logic is_last, status_t st);
    result_t r;
    r.out_byte   = b;
    r.last       = is_last;
    r.status     = st;
    r.used_count = COUNT_W'(ring_used());
    r.free_count = COUNT_W'(ring_free());
    expected_bytes.push_back(r);
  endfunction

  function automatic void predict_buffer(req_item_t it);
    logic [DATA_W-1:0] taken [DEPTH];
    int unsigned       n;
    int unsigned       idx;
    status_t           st;
    case (it.op)
      OP_WRITE: begin
        st = ST_REJECT;
        if (it.block_first)
          block_open = (it.block_length != 0) && (it.block_length <= ring_free());
        if (block_open) begin
          if (ring_free() > 0) begin
            ring[wr_idx] = it.data_byte;
            wr_idx = (wr_idx + 1) % DEPTH;
            st = ST_OK;
          end else begin
            // A byte that finds the buffer full ends the block.
            block_open = 1'b0;
          end
        end
        add_expected('0, 1'b1, st);
      end
      OP_READ: begin
        n = it.read_count;
        if (n > ring_used())
          n = ring_used();
        if (n == 0) begin
          add_expected('0, 1'b1, ST_EMPTY);
        end else begin
          for (int i = 0; i < n; i++) begin
            taken[i] = ring[rd_idx];
            rd_idx = (rd_idx + 1) % DEPTH;
          end
          for (int i = 0; i < n; i++)
            add_expected(taken[i], i == n - 1, ST_OK);
        end
      end
      OP_LINE: begin
        n = 0;
        idx = rd_idx;
        for (int i = 0; i < ring_used() && n == 0; i++) begin
          taken[i] = ring[idx];
          idx = (idx + 1) % DEPTH;
          if (taken[i] == CHAR_CR || taken[i] == CHAR_LF || taken[i] == CHAR_NUL)
            n = i + 1;
        end
        if (n == 0) begin
          add_expected('0, 1'b1, ST_NO_LINE);
        end else begin
          taken[n-1] = '0;
          rd_idx = idx;
          for (int i = 0; i < n; i++)
            add_expected(taken[i], i == n - 1, ST_OK);
        end
      end
      default: begin
        wr_idx = 0;
        rd_idx = 0;
        block_open = 1'b0;
        add_expected('0, 1'b1, ST_OK);
      end
    endcase
  endfunction

  function automatic req_item_t any_item(op_t op);
    req_item_t it;
    it.op           = op;
    it.data_byte    = DATA_W'($urandom);
    it.block_length = LEN_W'($urandom);
    it.block_first  = 1'($urandom);
    it.read_count   = LEN_W'($urandom);
    it.drain        = 1'b0;
    return it;
  endfunction

  function automatic req_item_t write_item(logic [DATA_W-1:0] b, int blen, logic first);
    req_item_t it;
    it = any_item(OP_WRITE);
    it.data_byte    = b;
    it.block_length = LEN_W'(blen);
    it.block_first  = first;
    return it;
  endfunction

  function automatic req_item_t read_item(int n);
    req_item_t it;
    it = any_item(OP_READ);
    it.read_count = LEN_W'(n);
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] line_char();
    case ($urandom_range(0, 11))
      0:       return CHAR_CR;
      1:       return CHAR_LF;
      2:       return CHAR_NUL;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic queue_block(int blen, int nbytes);
    for (int i = 0; i < nbytes; i++)
      pending_items.push_back(write_item(line_char(), blen, i == 0));
  endtask

  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t ns: %s", $time, msg);
  endtask

  // Source side: offers the next pending item once the previous one is taken.
  always @(posedge clk) begin
    logic      taken_now;
    req_item_t it;
    if (rst) begin
      req.valid <= 1'b0;
      src_gap   <= 0;
    end else begin
      taken_now = req.valid && req.ready;
      if (taken_now)
        sent_items <= sent_items + 1;
      if (!req.valid || taken_now) begin
        if (src_gap > 0) begin
          src_gap   <= src_gap - 1;
          req.valid <= 1'b0;
        end else if (src_idle_on && !hold_off && $urandom_range(0, 9) == 0) begin
          src_gap   <= $urandom_range(0, 12);
          req.valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain || (!taken_now && done_items == sent_items))) begin
          it = pending_items.pop_front();
          req.valid        <= 1'b1;
          req.operation    <= it.op;
          req.data_byte    <= it.data_byte;
          req.block_length <= it.block_length;
          req.block_first  <= it.block_first;
          req.read_count   <= it.read_count;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      snk_gap   <= 0;
    end else if (hold_off) begin
      rsp.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap   <= snk_gap - 1;
      rsp.ready <= 1'b0;
    end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
      snk_gap   <= $urandom_range(0, 12);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Predicts on every accepted item, then checks any result taken at the same edge.
  always @(posedge clk) begin
    req_item_t it;
    result_t   got;
    result_t   want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        it.op           = op_t'(req.operation);
        it.data_byte    = req.data_byte;
        it.block_length = req.block_length;
        it.block_first  = req.block_first;
        it.read_count   = req.read_count;
        it.drain        = 1'b0;
        predict_buffer(it);
      end
      if (rsp.valid && rsp.ready) begin
        got.out_byte   = rsp.out_byte;
        got.last       = rsp.last;
        got.status     = status_t'(rsp.status);
        got.used_count = rsp.used_count;
        got.free_count = rsp.free_count;
        if (expected_bytes.size() == 0) begin
          flag_error($sformatf("unexpected result: byte %h last %b status %0d used %0d free %0d",
                               got.out_byte, got.last, got.status, got.used_count,
                               got.free_count));
        end else begin
          want = expected_bytes.pop_front();
          if (want.last)
            done_items <= done_items + 1;
          if (got.out_byte !== want.out_byte || got.last !== want.last ||
              got.status !== want.status || got.used_count !== want.used_count ||
              got.free_count !== want.free_count)
            flag_error($sformatf({"mismatch: byte %h/%h last %b/%b status %0d/%0d ",
                                  "used %0d/%0d free %0d/%0d (expected/actual)"},
                                 want.out_byte, got.out_byte, want.last, got.last,
                                 want.status, got.status, want.used_count, got.used_count,
                                 want.free_count, got.free_count));
        end
      end
    end
  end

  // Long hold-off on the result side while items keep being offered.
  initial begin
    while (sent_items < 120)
      @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int        sel;
    int        blen;
    int        nbytes;
    int        first_idx;
    int        fills;
    req_item_t it;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.operation    = '0;
    req.data_byte    = '0;
    req.block_length = '0;
    req.block_first  = 1'b0;
    req.read_count   = '0;
    rsp.ready        = 1'b0;

    pending_items.push_back(any_item(OP_LINE));          // empty buffer, no line
    pending_items.push_back(read_item(5));               // empty buffer
    pending_items.push_back(write_item(8'h41, 0, 1'b1)); // zero length block
    pending_items.push_back(write_item(8'h42, 3, 1'b0)); // continuation with no block open
    pending_items.push_back(write_item(8'h41, 3, 1'b1));
    pending_items.push_back(write_item(8'h42, 3, 1'b0));
    pending_items.push_back(write_item(CHAR_CR, 3, 1'b0));
    pending_items.push_back(write_item(8'h43, 2, 1'b1));
    pending_items.push_back(write_item(CHAR_LF, 2, 1'b0));
    pending_items.push_back(write_item(8'hFF, 2, 1'b1));
    pending_items.push_back(write_item(CHAR_NUL, 2, 1'b0));
    pending_items.push_back(any_item(OP_LINE));
    pending_items.push_back(any_item(OP_LINE));
    pending_items.push_back(read_item(0));
    pending_items.push_back(read_item(127));
    pending_items.push_back(write_item(8'h58, 127, 1'b1)); // longer than any buffer
    pending_items.push_back(write_item(8'h58, 64, 1'b1));  // one above the free count
    pending_items.push_back(write_item(8'h58, 1, 1'b1));
    pending_items.push_back(any_item(OP_LINE));            // stored byte but no terminator
    pending_items.push_back(write_item(8'h59, 2, 1'b1));   // block cut short by a clear
    pending_items.push_back(any_item(OP_CLEAR));
    pending_items.push_back(write_item(8'h5A, 2, 1'b0));
    pending_items.push_back(read_item(1));

    fills = 0;
    while (pending_items.size() < 300) begin
      first_idx = pending_items.size();
      sel = (fills == 0) ? 86 : $urandom_range(0, 99);
      if (sel < 45) begin
        case ($urandom_range(0, 15))
          0:       blen = 0;
          1:       blen = $urandom_range(64, 127);
          2, 3:    blen = $urandom_range(9, 63);
          default: blen = $urandom_range(1, 8);
        endcase
        nbytes = (blen >= 1 && blen <= 63) ? blen : $urandom_range(1, 3);
        case ($urandom_range(0, 7))
          0:       nbytes = nbytes + $urandom_range(1, 3);
          1:       nbytes = $urandom_range(1, nbytes);
          default: ;
        endcase
        queue_block(blen, nbytes);
      end else if (sel < 65) begin
        if ($urandom_range(0, 9) == 0)
          pending_items.push_back(read_item($urandom_range(0, 1) ? 0 : $urandom_range(64, 127)));
        else
          pending_items.push_back(read_item($urandom_range(1, 16)));
      end else if (sel < 84) begin
        pending_items.push_back(any_item(OP_LINE));
      end else if (sel < 86) begin
        pending_items.push_back(any_item(OP_CLEAR));
      end else if (sel < 88 && fills < 2) begin
        // Fill the buffer to the brim, sometimes overrun it, then empty it in one read.
        fills++;
        pending_items.push_back(any_item(OP_CLEAR));
        queue_block(DEPTH - 1, DEPTH - 1 + $urandom_range(0, 2));
        pending_items.push_back(read_item(127));
      end else begin
        it = any_item(op_t'($urandom_range(0, 3)));
        pending_items.push_back(it);
      end
      if (first_idx == 23 || $urandom_range(0, 19) == 0)
        pending_items[first_idx].drain = 1'b1;
    end
    total_items = pending_items.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || req.valid || done_items != sent_items)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_bytes.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", expected_bytes.size()));

    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lrb_pkg.sv
hw/rtl/lrb_req_if.sv
hw/rtl/lrb_rsp_if.sv
hw/rtl/lrb_ram.sv
hw/rtl/lrb_ctrl.sv
hw/rtl/lrb_dp.sv
hw/rtl/line_ring_buffer.sv
sim/line_ring_buffer_tb.sv
